// File: design/csag_pkg.sv
// ----------------------------------------------------------------------------
// csag_pkg: shared types and constants for the color sensor auto-gain block
// Derivation of integration steps, base gain and full scale from the poll
// interval, gain ratio table and result transaction type.
// ----------------------------------------------------------------------------
package csag_pkg;

   localparam int CHANNELS  = 4;
   localparam int COUNT_W   = 16;
   localparam int NORM_W    = 24;
   localparam int GAIN_W    = 2;
   localparam int FACTOR_W  = 8;
   localparam int POLL_W    = 16;
   localparam int STEPS_W   = 9;
   localparam int FS_W      = 16;
   localparam int FS19_W    = 21;
   localparam int ICODE_W   = 8;
   localparam int ADDR_W    = 3;
   localparam int DATA_W    = 32;

   localparam logic [0:0]        REG_POLL   = 1'b0;
   localparam logic [POLL_W-1:0] RESET_POLL = 16'd100;

   localparam logic [GAIN_W-1:0] GAIN_1X  = 2'd0;
   localparam logic [GAIN_W-1:0] GAIN_4X  = 2'd1;
   localparam logic [GAIN_W-1:0] GAIN_16X = 2'd2;
   localparam logic [GAIN_W-1:0] GAIN_60X = 2'd3;

   typedef struct packed {
      logic [GAIN_W-1:0]  base;
      logic [FS_W-1:0]    fs;
      logic [FS19_W-1:0]  fs19;
      logic [ICODE_W-1:0] int_code;
   } cfg_type;

   typedef struct packed {
      logic              load;
      logic [GAIN_W-1:0] base;
   } gain_load_type;

   typedef struct packed {
      logic [CHANNELS-1:0][NORM_W-1:0] norm;
      logic [GAIN_W-1:0]               next_gain;
      logic                            changed;
      logic [ICODE_W-1:0]              int_code;
   } rsp_type;

   // steps = round(clamp(poll - 10, 2.4, 614.4) / 2.4) = (5t + 6) / 12
   // /12 done as /4 then x/3 by reciprocal 683/2048 (exact for x < 770)
   function automatic cfg_type derive_cfg(input logic [POLL_W-1:0] poll);
      logic [9:0]         t;
      logic [11:0]        x;
      logic [19:0]        prod;
      logic [STEPS_W-1:0] steps;
      logic [FS_W-1:0]    fs;
      cfg_type            c;
      t    = 10'(poll - 16'd10);
      x    = 12'(t) * 12'd5 + 12'd6;
      prod = 20'(x[11:2]) * 20'd683;
      if (poll <= 16'd12) begin
         steps = 9'd1;
      end else if (poll >= 16'd625) begin
         steps = 9'd256;
      end else begin
         steps = prod[19:11];
      end
      if (steps <= 9'd8) begin
         c.base = GAIN_60X;
      end else if (steps <= 9'd33) begin
         c.base = GAIN_16X;
      end else if (steps <= 9'd83) begin
         c.base = GAIN_4X;
      end else begin
         c.base = GAIN_1X;
      end
      fs         = (steps >= 9'd64) ? 16'hFFFF : {steps[5:0], 10'b0};
      c.fs       = fs;
      c.fs19     = 21'(fs) * 21'd19;
      c.int_code = 8'(9'd256 - steps);
      return c;
   endfunction

   // 4 * gain_x[base] / gain_x[cur]; cur never exceeds base
   function automatic logic [FACTOR_W-1:0] scale_factor(input logic [GAIN_W-1:0] base,
                                                        input logic [GAIN_W-1:0] cur);
      logic [FACTOR_W-1:0] f;
      case ({base, cur})
         {GAIN_4X,  GAIN_1X}:  f = 8'd16;
         {GAIN_16X, GAIN_1X}:  f = 8'd64;
         {GAIN_60X, GAIN_1X}:  f = 8'd240;
         {GAIN_16X, GAIN_4X}:  f = 8'd16;
         {GAIN_60X, GAIN_4X}:  f = 8'd60;
         {GAIN_60X, GAIN_16X}: f = 8'd15;
         default:              f = 8'd4;
      endcase
      return f;
   endfunction

endpackage

// File: design/csag_lane.sv
// ----------------------------------------------------------------------------
// csag_lane: per-channel gain normalization
// Scales one raw count by the base/current gain ratio, 2 fraction bits.
// ----------------------------------------------------------------------------
module csag_lane
   import csag_pkg::*;
(
   input  logic [COUNT_W-1:0]  count,
   input  logic [FACTOR_W-1:0] factor,
   output logic [NORM_W-1:0]   norm
);

   assign norm = NORM_W'(count) * NORM_W'(factor);

endmodule

// File: design/csag_merge.sv
// ----------------------------------------------------------------------------
// csag_merge: peak detect and gain decision
// Finds the channel peak and steps the gain down on near-clip, up on dim.
// ----------------------------------------------------------------------------
module csag_merge
   import csag_pkg::*;
(
   input  logic [CHANNELS-1:0][COUNT_W-1:0] counts,
   input  logic [GAIN_W-1:0]                cur_gain,
   input  cfg_type                          cfg,
   output logic [GAIN_W-1:0]                next_gain
);

   logic [COUNT_W-1:0] peak;
   logic [FS19_W-1:0]  peak20;
   logic [19:0]        peak10;
   logic               near_clip;
   logic               dim;

   always_comb begin
      peak = '0;
      for (int i = 0; i < CHANNELS; i++) begin
         if (counts[i] > peak) begin
            peak = counts[i];
         end
      end
   end

   assign peak20    = FS19_W'(peak) * FS19_W'(20);
   assign peak10    = 20'(peak) * 20'd10;
   assign near_clip = peak20 >= cfg.fs19;
   assign dim       = peak10 <= 20'(cfg.fs);

   always_comb begin
      if (near_clip && cur_gain != GAIN_1X) begin
         next_gain = cur_gain - 2'd1;
      end else if (dim && cur_gain < cfg.base) begin
         next_gain = cur_gain + 2'd1;
      end else begin
         next_gain = cur_gain;
      end
   end

endmodule

// File: design/csag_cfg.sv
// ----------------------------------------------------------------------------
// csag_cfg: APB register file
// Holds the poll interval and the settings derived from it on each write.
// ----------------------------------------------------------------------------
module csag_cfg
   import csag_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [ADDR_W-1:0] paddr,
   input  logic [DATA_W-1:0] pwdata,
   output logic [DATA_W-1:0] prdata,
   output logic              pready,
   output cfg_type           cfg,
   output gain_load_type     gain_load
);

   logic [POLL_W-1:0] poll_ff, poll_in;
   cfg_type           cfg_ff, cfg_in;
   cfg_type           derived;
   logic              wr;

   assign pready  = 1'b1;
   assign wr      = psel && penable && pwrite && (paddr[2] == REG_POLL);
   assign derived = derive_cfg(pwdata[POLL_W-1:0]);

   always_comb begin
      poll_in = poll_ff;
      cfg_in  = cfg_ff;
      if (wr) begin
         poll_in = pwdata[POLL_W-1:0];
         cfg_in  = derived;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         poll_ff <= RESET_POLL;
         cfg_ff  <= derive_cfg(RESET_POLL);
      end else begin
         poll_ff <= poll_in;
         cfg_ff  <= cfg_in;
      end
   end

   assign prdata         = (paddr[2] == REG_POLL) ? DATA_W'(poll_ff) : '0;
   assign cfg            = cfg_ff;
   assign gain_load.load = wr;
   assign gain_load.base = derived.base;

endmodule

// File: design/color_sensor_auto_gain.sv
// ----------------------------------------------------------------------------
// color_sensor_auto_gain: auto-gain normalizer for a four-channel color sensor
// Output: accepted req registered into rsp; a skid register absorbs one stall.
// Throughput: one transaction per cycle while the skid is empty; peak, gain
//   step and lane multiplies all settle in the accept cycle.
// Reset: synchronous; poll interval 100 ms, gain step 4x, outputs empty.
// ----------------------------------------------------------------------------
module color_sensor_auto_gain
   import csag_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic [COUNT_W-1:0]  req_clear_count,
   input  logic [COUNT_W-1:0]  req_red_count,
   input  logic [COUNT_W-1:0]  req_green_count,
   input  logic [COUNT_W-1:0]  req_blue_count,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic [NORM_W-1:0]   rsp_norm_clear,
   output logic [NORM_W-1:0]   rsp_norm_red,
   output logic [NORM_W-1:0]   rsp_norm_green,
   output logic [NORM_W-1:0]   rsp_norm_blue,
   output logic [GAIN_W-1:0]   rsp_next_gain_code,
   output logic                rsp_gain_changed,
   output logic [ICODE_W-1:0]  rsp_integration_code,
   input  logic                psel,
   input  logic                penable,
   input  logic                pwrite,
   input  logic [ADDR_W-1:0]   paddr,
   input  logic [DATA_W-1:0]   pwdata,
   output logic [DATA_W-1:0]   prdata,
   output logic                pready
);

   localparam cfg_type RESET_CFG = derive_cfg(RESET_POLL);

   cfg_type                          cfg;
   gain_load_type                    gain_load;
   logic [CHANNELS-1:0][COUNT_W-1:0] counts;
   logic [CHANNELS-1:0][NORM_W-1:0]  norm;
   logic [FACTOR_W-1:0]              factor;
   logic [GAIN_W-1:0]                next_gain;
   logic [GAIN_W-1:0]                cur_gain_ff, cur_gain_in;
   rsp_type                          result;
   rsp_type                          out_ff, out_in;
   rsp_type                          skid_ff, skid_in;
   logic                             rsp_valid_ff, rsp_valid_in;
   logic                             skid_valid_ff, skid_valid_in;
   logic                             accept;

   csag_cfg u_cfg (
      .clock     (clock),
      .reset     (reset),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready),
      .cfg       (cfg),
      .gain_load (gain_load)
   );

   assign counts[0] = req_clear_count;
   assign counts[1] = req_red_count;
   assign counts[2] = req_green_count;
   assign counts[3] = req_blue_count;
   assign factor    = scale_factor(cfg.base, cur_gain_ff);

   for (genvar g = 0; g < CHANNELS; g++) begin : g_lane
      csag_lane u_lane (
         .count  (counts[g]),
         .factor (factor),
         .norm   (norm[g])
      );
   end

   csag_merge u_merge (
      .counts    (counts),
      .cur_gain  (cur_gain_ff),
      .cfg       (cfg),
      .next_gain (next_gain)
   );

   assign result.norm      = norm;
   assign result.next_gain = next_gain;
   assign result.changed   = next_gain != cur_gain_ff;
   assign result.int_code  = cfg.int_code;

   assign req_ready = !skid_valid_ff;
   assign accept    = req_valid && req_ready;

   always_comb begin
      cur_gain_in = cur_gain_ff;
      if (gain_load.load) begin
         cur_gain_in = gain_load.base;
      end else if (accept) begin
         cur_gain_in = next_gain;
      end
   end

   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      rsp_valid_in  = rsp_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (!rsp_valid_ff || rsp_ready) begin
         if (skid_valid_ff) begin
            out_in        = skid_ff;
            rsp_valid_in  = 1'b1;
            skid_valid_in = 1'b0;
         end else begin
            out_in       = result;
            rsp_valid_in = accept;
         end
      end else if (accept) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_gain_ff   <= RESET_CFG.base;
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         cur_gain_ff   <= cur_gain_in;
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_norm_clear       = out_ff.norm[0];
   assign rsp_norm_red         = out_ff.norm[1];
   assign rsp_norm_green       = out_ff.norm[2];
   assign rsp_norm_blue        = out_ff.norm[3];
   assign rsp_next_gain_code   = out_ff.next_gain;
   assign rsp_gain_changed     = out_ff.changed;
   assign rsp_integration_code = out_ff.int_code;

   a_gain_le_base: assert property (@(posedge clock) disable iff (reset)
      cur_gain_ff <= cfg.base)
      else $error("gain step above base gain");

   a_skid_implies_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid holds a transaction while output is empty");

   a_gain_follows: assert property (@(posedge clock) disable iff (reset)
      (accept && !gain_load.load) |=> cur_gain_ff == $past(next_gain))
      else $error("gain step not advanced on accepted transaction");

   a_changed_flag: assert property (@(posedge clock) disable iff (reset)
      (accept && (!rsp_valid_ff || rsp_ready) && !skid_valid_ff) |=>
         out_ff.changed == (out_ff.next_gain != $past(cur_gain_ff)))
      else $error("gain_changed inconsistent with gain steps");

endmodule
